// ----- rtl/core/rcpf_pkg.sv -----
package rcpf_pkg;

  localparam int CFG_AW = 2;
  localparam int CFG_DW = 12;

  localparam logic [CFG_AW-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_AW-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_AW-1:0] REG_UPSIDE = 2'd2;

  localparam logic [9:0]  WIDTH_RST  = 10'd384;
  localparam logic [11:0] HEIGHT_RST = 12'd1;
  localparam logic        UPSIDE_RST = 1'b1;

  localparam logic [7:0] B_ESC  = 8'h1B;
  localparam logic [7:0] B_DC2  = 8'h12;
  localparam logic [7:0] B_GS   = 8'h1D;
  localparam logic [7:0] B_LBRC = 8'h7B;
  localparam logic [7:0] B_A    = 8'h61;
  localparam logic [7:0] B_HASH = 8'h23;
  localparam logic [7:0] B_3    = 8'h33;
  localparam logic [7:0] B_V    = 8'h76;
  localparam logic [7:0] B_0    = 8'h30;
  localparam logic [7:0] B_D    = 8'h64;
  localparam logic [7:0] DARK_MAX  = 8'h9F;
  localparam logic [7:0] DARK_NORM = 8'h58;
  localparam logic [7:0] FEED_LINES = 8'h03;
  localparam logic [7:0] ALIGN_CTR  = 8'h01;
  localparam logic [7:0] ZERO_BYTE  = 8'h00;

  localparam int IDX_W   = 4;
  localparam int PRE_LEN = 12;
  localparam int HDR_LEN = 8;
  localparam int TRL_LEN = 6;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  typedef struct packed {
    logic [7:0]  data;
    logic        pre;
    logic        hdr;
    logic        trl;
    logic        ud;
    logic [15:0] bpl;
    logic [7:0]  lines;
  } entry_t;

  typedef struct packed {
    logic valid;
    logic ready;
  } hs_t;

  typedef enum logic [4:0] {
    S_NEW = 5'b00001,
    S_PRE = 5'b00010,
    S_HDR = 5'b00100,
    S_DAT = 5'b01000,
    S_TRL = 5'b10000
  } phase_t;

  function automatic logic [7:0] pre_byte(input logic [IDX_W-1:0] idx, input logic ud);
    logic [7:0] b;
    unique case (idx)
      4'd0:    b = B_ESC;
      4'd1:    b = B_LBRC;
      4'd2:    b = {7'd0, ud};
      4'd3:    b = B_ESC;
      4'd4:    b = B_A;
      4'd5:    b = ALIGN_CTR;
      4'd6:    b = B_DC2;
      4'd7:    b = B_HASH;
      4'd8:    b = DARK_MAX;
      4'd9:    b = B_ESC;
      4'd10:   b = B_3;
      default: b = ZERO_BYTE;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] hdr_byte(input logic [IDX_W-1:0] idx,
                                          input logic [15:0] bpl,
                                          input logic [7:0] lines);
    logic [7:0] b;
    unique case (idx)
      4'd0:    b = B_GS;
      4'd1:    b = B_V;
      4'd2:    b = B_0;
      4'd4:    b = bpl[7:0];
      4'd5:    b = bpl[15:8];
      4'd6:    b = lines;
      default: b = ZERO_BYTE;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] trl_byte(input logic [IDX_W-1:0] idx);
    logic [7:0] b;
    unique case (idx)
      4'd0:    b = B_ESC;
      4'd1:    b = B_D;
      4'd2:    b = FEED_LINES;
      4'd3:    b = B_DC2;
      4'd4:    b = B_HASH;
      4'd5:    b = DARK_NORM;
      default: b = ZERO_BYTE;
    endcase
    return b;
  endfunction

endpackage

// ----- rtl/core/rcpf_front.sv -----
module rcpf_front #(
  parameter int BAND_LINES     = 24,
  parameter int MAX_WIDTH_DOTS = 512
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [rcpf_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [rcpf_pkg::CFG_DW-1:0] cfg_wdata,
  input  logic [7:0]                  in_data,
  input  rcpf_pkg::hs_t               in_hs,
  output rcpf_pkg::entry_t            push_entry
);

  localparam int WCW_RAW = $clog2(MAX_WIDTH_DOTS + 1);
  localparam int WCW     = (WCW_RAW > 10) ? WCW_RAW : 10;
  localparam int BPL_W   = $clog2((MAX_WIDTH_DOTS + 7) / 8 + 1);
  localparam int RIB_W   = $clog2(BAND_LINES + 1);

  logic [9:0]       width_r;
  logic [11:0]      height_r;
  logic             ud_r;
  logic             active_r, active_nxt;
  logic [BPL_W-1:0] cc_r, cc_nxt;
  logic [RIB_W-1:0] rib_r, rib_nxt;
  logic [11:0]      lr_r, lr_nxt;

  logic [WCW-1:0]   w_c;
  logic [WCW-1:0]   bpl_full;
  logic [BPL_W-1:0] bpl;
  logic             pre;
  logic [11:0]      lr;
  logic [RIB_W-1:0] rib, rib1;
  logic [BPL_W-1:0] cc, cc1;
  logic [11:0]      lr_dec;
  logic             line_end;
  logic             accept;

  assign accept = in_hs.valid & in_hs.ready;

  always_comb begin
    w_c = WCW'(width_r);
    if (width_r == 10'd0) begin
      w_c = WCW'(1);
    end else if (WCW'(width_r) > WCW'(MAX_WIDTH_DOTS)) begin
      w_c = WCW'(MAX_WIDTH_DOTS);
    end
    bpl_full = (w_c + WCW'(7)) >> 3;
    bpl      = bpl_full[BPL_W-1:0];
  end

  always_comb begin
    pre = ~active_r;
    lr  = pre ? ((height_r == 12'd0) ? 12'd1 : height_r) : lr_r;
    rib = pre ? '0 : rib_r;
    cc  = pre ? '0 : cc_r;

    cc1      = cc + BPL_W'(1);
    line_end = (cc1 >= bpl);
    lr_dec   = (lr != 12'd0) ? (lr - 12'd1) : 12'd0;
    rib1     = rib + RIB_W'(1);

    cc_nxt     = cc1;
    lr_nxt     = lr;
    rib_nxt    = rib;
    active_nxt = 1'b1;
    if (line_end) begin
      cc_nxt  = '0;
      lr_nxt  = lr_dec;
      rib_nxt = ((rib1 >= RIB_W'(BAND_LINES)) || (lr_dec == 12'd0)) ? '0 : rib1;
      if (lr_dec == 12'd0) begin
        active_nxt = 1'b0;
      end
    end

    push_entry.data  = in_data;
    push_entry.pre   = pre;
    push_entry.hdr   = (cc == '0) && (rib == '0);
    push_entry.trl   = line_end && (lr_dec == 12'd0);
    push_entry.ud    = ud_r;
    push_entry.bpl   = 16'(bpl);
    push_entry.lines = (lr > 12'(BAND_LINES)) ? 8'(BAND_LINES) : lr[7:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= rcpf_pkg::WIDTH_RST;
      height_r <= rcpf_pkg::HEIGHT_RST;
      ud_r     <= rcpf_pkg::UPSIDE_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        rcpf_pkg::REG_WIDTH:  width_r  <= cfg_wdata[9:0];
        rcpf_pkg::REG_HEIGHT: height_r <= cfg_wdata[11:0];
        rcpf_pkg::REG_UPSIDE: ud_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      cc_r     <= '0;
      rib_r    <= '0;
      lr_r     <= '0;
    end else if (accept) begin
      active_r <= active_nxt;
      cc_r     <= cc_nxt;
      rib_r    <= rib_nxt;
      lr_r     <= lr_nxt;
    end
  end

endmodule

// ----- rtl/core/rcpf_fifo.sv -----
module rcpf_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  rcpf_pkg::entry_t wr_entry,
  input  logic             wr_valid,
  output logic             wr_ready,
  output rcpf_pkg::entry_t rd_entry,
  output logic             rd_valid,
  input  logic             rd_pop
);

  localparam int AW = rcpf_pkg::FIFO_AW;

  rcpf_pkg::entry_t mem_r [rcpf_pkg::FIFO_DEPTH];
  logic [AW-1:0]    wp_r, rp_r;
  logic [AW:0]      cnt_r, cnt_nxt;
  logic             push, pop;

  assign wr_ready = (cnt_r != (AW + 1)'(rcpf_pkg::FIFO_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_entry = mem_r[rp_r];
  assign push     = wr_valid & wr_ready;
  assign pop      = rd_pop & rd_valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + (AW + 1)'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - (AW + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wp_r <= wp_r + AW'(1);
      end
      if (pop) begin
        rp_r <= rp_r + AW'(1);
      end
    end
  end

endmodule

// ----- rtl/core/rcpf_back.sv -----
module rcpf_back (
  input  logic             clk,
  input  logic             rst_n,
  input  rcpf_pkg::entry_t head,
  input  logic             head_valid,
  output logic             head_pop,
  output logic [7:0]       out_byte,
  output logic             out_valid,
  output logic             out_last,
  output logic             out_done,
  input  logic             out_ready
);

  localparam int IW = rcpf_pkg::IDX_W;

  rcpf_pkg::phase_t st_r, st_nxt, ph;
  logic [IW-1:0]    ix_r, ix_nxt, ix;
  logic [7:0]       byte_c;
  logic             end_c, done_c, load;
  logic             valid_r;
  logic [7:0]       byte_r;
  logic             last_r, done_r;

  assign load = head_valid & (~valid_r | out_ready);

  always_comb begin
    if (st_r == rcpf_pkg::S_NEW) begin
      ph = head.pre ? rcpf_pkg::S_PRE : (head.hdr ? rcpf_pkg::S_HDR : rcpf_pkg::S_DAT);
      ix = '0;
    end else begin
      ph = st_r;
      ix = ix_r;
    end

    byte_c = 8'h00;
    end_c  = 1'b0;
    done_c = 1'b0;
    st_nxt = ph;
    ix_nxt = ix + IW'(1);
    unique case (ph)
      rcpf_pkg::S_PRE: begin
        byte_c = rcpf_pkg::pre_byte(ix, head.ud);
        if (ix == IW'(rcpf_pkg::PRE_LEN - 1)) begin
          st_nxt = head.hdr ? rcpf_pkg::S_HDR : rcpf_pkg::S_DAT;
          ix_nxt = '0;
        end
      end
      rcpf_pkg::S_HDR: begin
        byte_c = rcpf_pkg::hdr_byte(ix, head.bpl, head.lines);
        if (ix == IW'(rcpf_pkg::HDR_LEN - 1)) begin
          st_nxt = rcpf_pkg::S_DAT;
          ix_nxt = '0;
        end
      end
      rcpf_pkg::S_DAT: begin
        byte_c = head.data;
        ix_nxt = '0;
        if (head.trl) begin
          st_nxt = rcpf_pkg::S_TRL;
        end else begin
          st_nxt = rcpf_pkg::S_NEW;
          end_c  = 1'b1;
        end
      end
      rcpf_pkg::S_TRL: begin
        byte_c = rcpf_pkg::trl_byte(ix);
        if (ix == IW'(rcpf_pkg::TRL_LEN - 1)) begin
          st_nxt = rcpf_pkg::S_NEW;
          ix_nxt = '0;
          end_c  = 1'b1;
          done_c = 1'b1;
        end
      end
      default: begin
        st_nxt = rcpf_pkg::S_NEW;
        ix_nxt = '0;
      end
    endcase
  end

  assign head_pop = load & end_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= rcpf_pkg::S_NEW;
      ix_r    <= '0;
      valid_r <= 1'b0;
    end else begin
      if (load) begin
        st_r <= st_nxt;
        ix_r <= ix_nxt;
      end
      if (load) begin
        valid_r <= 1'b1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= byte_c;
      last_r <= end_c;
      done_r <= done_c;
    end
  end

  assign out_byte  = byte_r;
  assign out_valid = valid_r;
  assign out_last  = last_r;
  assign out_done  = done_r;

endmodule

// ----- rtl/core/raster_chunk_print_framer.sv -----
// Raster image to printer command stream framer.
// in_*  : one image byte per beat, row-major print order.
// out_* : command stream, one byte per beat; tlast marks the last byte caused
//         by an input beat, tuser marks the final trailer byte of the image.
// cfg_* : width_dots (0), image_height (1), upside_down (2); write only while
//         the block is idle. Height is latched when an image starts.
// The first beat of an image expands to 12 preamble bytes, every band start
// adds an 8-byte header, and the last beat appends a 6-byte trailer.
// An input beat is written into the queue and its first byte is then registered in
// the output stage, which drives out_tvalid. Throughput: one output beat per cycle
// while out_tready is high; plain data beats pass at one per cycle, an expanded beat
// emits up to 27 bytes while the 4-entry queue keeps taking input until it fills.
// Reset (synchronous, rst_n low) returns to idle, empties the queue, drops
// out_tvalid and restores register defaults.
// When out_tready is low the output beat holds; input stalls once the queue
// is full.
module raster_chunk_print_framer #(
  parameter int BAND_LINES     = 24,
  parameter int MAX_WIDTH_DOTS = 512
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [rcpf_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [rcpf_pkg::CFG_DW-1:0] cfg_wdata,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // [7:0] image_byte
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [7:0]                  out_tdata,  // [7:0] out_byte
  output logic                        out_tlast,
  output logic                        out_tuser   // [0] image_done
);

  rcpf_pkg::entry_t push_entry, head;
  rcpf_pkg::hs_t    in_hs;
  logic             head_valid, head_pop;

  assign in_hs.valid = in_tvalid;
  assign in_hs.ready = in_tready;

  rcpf_front #(
    .BAND_LINES     (BAND_LINES),
    .MAX_WIDTH_DOTS (MAX_WIDTH_DOTS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_data    (in_tdata),
    .in_hs      (in_hs),
    .push_entry (push_entry)
  );

  rcpf_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_entry (push_entry),
    .wr_valid (in_tvalid),
    .wr_ready (in_tready),
    .rd_entry (head),
    .rd_valid (head_valid),
    .rd_pop   (head_pop)
  );

  rcpf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (head_valid),
    .head_pop   (head_pop),
    .out_byte   (out_tdata),
    .out_valid  (out_tvalid),
    .out_last   (out_tlast),
    .out_done   (out_tuser),
    .out_ready  (out_tready)
  );

endmodule

// ----- rtl/core/rcpf_checker.sv -----
module rcpf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast,
  input logic       out_tuser
);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid)
    else $error("input beat withdrawn while stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tlast) && $stable(out_tuser))
    else $error("output beat changed while stalled");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("image_done without run_last");

  a_done_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == rcpf_pkg::DARK_NORM)
    else $error("image_done not on darkness restore byte");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule

bind raster_chunk_print_framer rcpf_checker u_rcpf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

  localparam int BAND_LINES     = 24;
  localparam int MAX_WIDTH_DOTS = 512;
  localparam int STALL_LIMIT    = 2000;
  localparam int HOLD_CYCLES    = 100;

  typedef struct packed {
    logic [7:0] data;
    logic       run_end;
    logic       img_end;
  } cmd_beat_t;

  typedef logic [rcpf_pkg::CFG_DW-1:0] cfg_word_t;

  logic                        clk        = 1'b0;
  logic                        rst_n      = 1'b0;
  logic                        cfg_we     = 1'b0;
  logic [rcpf_pkg::CFG_AW-1:0] cfg_addr   = '0;
  cfg_word_t                   cfg_wdata  = '0;
  logic                        in_tvalid  = 1'b0;
  logic                        in_tready;
  logic [7:0]                  in_tdata   = '0;
  logic                        out_tvalid;
  logic                        out_tready = 1'b0;
  logic [7:0]                  out_tdata;
  logic                        out_tlast;
  logic                        out_tuser;

  // printer stream still owed by the block
  cmd_beat_t cmd_q[$];
  int        mismatches = 0;
  int        stall_cycles = 0;
  int        hold_left = 0;
  logic      hold_req = 1'b0;
  logic      steady = 1'b0;

  // shadow registers and framing state
  logic [9:0]  width_reg;
  logic [11:0] height_reg;
  logic        upside_reg;
  logic [6:0]  col_cnt;
  logic [4:0]  band_row;
  logic [11:0] lines_left;
  logic        printing;

  raster_chunk_print_framer #(
    .BAND_LINES    (BAND_LINES),
    .MAX_WIDTH_DOTS(MAX_WIDTH_DOTS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  always #1 clk = ~clk;

  function automatic int line_bytes(input logic [9:0] w);
    int d;
    d = w;
    if (d < 1) d = 1;
    if (d > MAX_WIDTH_DOTS) d = MAX_WIDTH_DOTS;
    return (d + 7) / 8;
  endfunction

  function automatic void frame_byte(input logic [7:0] pix);
    logic [7:0]  seq [0:26];
    logic [11:0] band;
    logic [6:0]  bpl;
    logic        fin;
    int          n;
    n   = 0;
    fin = 1'b0;
    bpl = 7'(line_bytes(width_reg));
    if (!printing) begin
      seq[0]  = rcpf_pkg::B_ESC;
      seq[1]  = rcpf_pkg::B_LBRC;
      seq[2]  = {7'd0, upside_reg};
      seq[3]  = rcpf_pkg::B_ESC;
      seq[4]  = rcpf_pkg::B_A;
      seq[5]  = rcpf_pkg::ALIGN_CTR;
      seq[6]  = rcpf_pkg::B_DC2;
      seq[7]  = rcpf_pkg::B_HASH;
      seq[8]  = rcpf_pkg::DARK_MAX;
      seq[9]  = rcpf_pkg::B_ESC;
      seq[10] = rcpf_pkg::B_3;
      seq[11] = rcpf_pkg::ZERO_BYTE;
      n = 12;
      lines_left = (height_reg == 0) ? 12'd1 : height_reg;
      band_row   = '0;
      col_cnt    = '0;
      printing   = 1'b1;
    end
    if (col_cnt == 0 && band_row == 0) begin
      band = (lines_left > BAND_LINES) ? 12'(BAND_LINES) : lines_left;
      seq[n]   = rcpf_pkg::B_GS;
      seq[n+1] = rcpf_pkg::B_V;
      seq[n+2] = rcpf_pkg::B_0;
      seq[n+3] = rcpf_pkg::ZERO_BYTE;
      seq[n+4] = {1'b0, bpl};
      seq[n+5] = rcpf_pkg::ZERO_BYTE;
      seq[n+6] = band[7:0];
      seq[n+7] = {4'd0, band[11:8]};
      n = n + 8;
    end
    seq[n] = pix;
    n++;
    col_cnt = col_cnt + 7'd1;
    if (col_cnt >= bpl) begin
      col_cnt = '0;
      if (lines_left > 0) lines_left = lines_left - 12'd1;
      band_row = band_row + 5'd1;
      if (band_row >= BAND_LINES || lines_left == 0) band_row = '0;
      if (lines_left == 0) begin
        seq[n]   = rcpf_pkg::B_ESC;
        seq[n+1] = rcpf_pkg::B_D;
        seq[n+2] = rcpf_pkg::FEED_LINES;
        seq[n+3] = rcpf_pkg::B_DC2;
        seq[n+4] = rcpf_pkg::B_HASH;
        seq[n+5] = rcpf_pkg::DARK_NORM;
        n = n + 6;
        printing = 1'b0;
        fin      = 1'b1;
      end
    end
    for (int i = 0; i < n; i++)
      cmd_q.push_back(cmd_beat_t'{seq[i], i == n - 1, fin && (i == n - 1)});
  endfunction

  always @(posedge clk) begin
    cmd_beat_t want;
    if (!rst_n) begin
      width_reg  = rcpf_pkg::WIDTH_RST;
      height_reg = rcpf_pkg::HEIGHT_RST;
      upside_reg = rcpf_pkg::UPSIDE_RST;
      col_cnt    = '0;
      band_row   = '0;
      lines_left = '0;
      printing   = 1'b0;
    end else begin
      if (in_tvalid && in_tready) frame_byte(in_tdata);
      if (cfg_we) begin
        case (cfg_addr)
          rcpf_pkg::REG_WIDTH:  width_reg  = cfg_wdata[9:0];
          rcpf_pkg::REG_HEIGHT: height_reg = cfg_wdata[11:0];
          rcpf_pkg::REG_UPSIDE: upside_reg = cfg_wdata[0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (cmd_q.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected beat data=%h last=%b user=%b",
                     $realtime, out_tdata, out_tlast, out_tuser);
          mismatches++;
        end else begin
          want = cmd_q.pop_front();
          if ({out_tdata, out_tlast, out_tuser} !== {want.data, want.run_end, want.img_end}) begin
            if (mismatches < 10)
              $display("%0t: mismatch data %h/%h last %b/%b user %b/%b (exp/act)",
                       $realtime, want.data, out_tdata, want.run_end, out_tlast,
                       want.img_end, out_tuser);
            mismatches++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left  <= 0;
    end else if (hold_req) begin
      out_tready <= 1'b0;
      hold_left  <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else begin
      out_tready <= steady || ($urandom_range(99) >= 35);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_tvalid && in_tready) ||
        (out_tvalid && out_tready && cmd_q.size() != 0)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic write_reg(input logic [rcpf_pkg::CFG_AW-1:0] addr, input cfg_word_t val);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic push_byte(input logic [7:0] pix);
    if (!steady && $urandom_range(99) < 35) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic finish_image();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (cmd_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_image(input logic [9:0] w, input logic [11:0] h, input logic ud,
                           input logic [7:0] first, output int beats);
    write_reg(rcpf_pkg::REG_WIDTH, cfg_word_t'(w));
    write_reg(rcpf_pkg::REG_HEIGHT, h);
    write_reg(rcpf_pkg::REG_UPSIDE, cfg_word_t'(ud));
    beats = line_bytes(w) * ((h == 0) ? 1 : int'(h));
    push_byte(first);
    for (int i = 1; i < beats; i++) push_byte(8'($urandom_range(255)));
    finish_image();
  endtask

  task automatic test_reset_defaults();
    // height and mode keep their reset values
    steady = 1'b0;
    write_reg(rcpf_pkg::REG_WIDTH, cfg_word_t'(10'd8));
    push_byte(8'h00);
    finish_image();
  endtask

  task automatic test_tiny_images();
    int n;
    steady = 1'b0;
    run_image(10'd1, 12'd1, 1'b0, 8'h00, n);
    run_image(10'd1, 12'd1, 1'b1, 8'hFF, n);
    // zero width and zero height both act as one
    run_image(10'd0, 12'd0, 1'b0, 8'hA5, n);
    run_image(10'd8, 12'd3, 1'b1, 8'h5A, n);
    run_image(10'd9, 12'd2, 1'b0, 8'h80, n);
  endtask

  task automatic test_band_split();
    int n;
    steady = 1'b1;
    run_image(10'd8, 12'd26, 1'b0, 8'h3C, n);
    steady = 1'b0;
  endtask

  task automatic test_width_clamp();
    int n;
    steady = 1'b1;
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    run_image(10'd1023, 12'd1, 1'b1, 8'hC3, n);
    steady = 1'b0;
  endtask

  task automatic test_random_images();
    int          sent;
    int          n;
    logic [9:0]  w;
    logic [11:0] h;
    sent   = 0;
    steady = 1'b0;
    while (sent < 12) begin
      w = 10'($urandom_range(64, 0));
      h = 12'($urandom_range(4, 0));
      run_image(w, h, 1'($urandom_range(1)), 8'($urandom_range(255)), n);
      sent += n;
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_tiny_images();
    test_band_split();
    test_width_clamp();
    test_random_images();
    repeat (20) @(posedge clk);
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
